// ===== rtl/arbf_pkg.sv =====
`timescale 1ns / 1ps

package arbf_pkg;

    // fixed field widths
    localparam int COORD_W = 10;
    localparam int WIDTH_W = 11;
    localparam int SLOT_W  = 10;
    localparam int STAT_W  = 2;

    // largest grid side in cells
    localparam logic [WIDTH_W-1:0] GRID_MAX = 11'd1024;

    // item opcodes
    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_START = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STS_ROWS = 2'd1;
    localparam logic [STAT_W-1:0] STS_BADW = 2'd2;
    localparam logic [STAT_W-1:0] STS_FULL = 2'd3;

    // segment update commands broadcast to the cells
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_SHRINK = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_SEED   = 2'd3;

    // search record handed from cell to cell
    typedef struct packed {
        logic               active;
        logic [WIDTH_W-1:0] req_width;
        logic               best_hit;
        logic [SLOT_W-1:0]  best_idx;
        logic [COORD_W-1:0] best_x;
        logic [COORD_W-1:0] best_row;
        logic [WIDTH_W-1:0] best_width;
        logic               free_hit;
        logic [SLOT_W-1:0]  free_idx;
    } srch_t;

    // segment update command
    typedef struct packed {
        logic [1:0]         op;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] row;
        logic [WIDTH_W-1:0] width;
    } cmd_t;

endpackage

// ===== rtl/atlas_row_best_fit_packer.sv =====
`timescale 1ns / 1ps

// Row best-fit strip packer.
// Items enter on the s_ channel: s_tuser is the opcode (place or start),
// s_tdata the strip width. One result item per input item leaves on the m_
// channel with the column, row and status. cfg_valid/cfg_data write the
// grid side; write it only while the block is idle.
// A place request sends a search record down a chain of MAX_SEGMENTS cells,
// one cell per cycle, each holding one free segment; the record picks up the
// best-fitting segment and the lowest free slot. For a place item the record
// passes the injection register and every cell, the sequencer decides in the
// search state and the output state loads the output register; a start or a
// rejected width goes straight to the output state. One item is worked
// on at a time; the next item is accepted in the cycle after the result has
// gone to the output register, even while that result still waits.
// A stalled receiver holds the result in the output register; a following
// item that finishes before then waits in the block until the register frees.
// Reset clears the segment valid bits, the row count and sets the side to 16;
// there is no clearing pass and an item can be accepted right after reset.
module atlas_row_best_fit_packer #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // request_width [10:0], zero padding
    input  logic        s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // place_x [9:0], place_row [19:10], status [21:20]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // atlas_width
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_OUT    = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [arbf_pkg::WIDTH_W-1:0] side_cfg_reg;
    logic [arbf_pkg::COORD_W-1:0] rows_reg, rows_next;
    arbf_pkg::srch_t              inj_reg, inj_next;
    arbf_pkg::cmd_t               cmd_reg, cmd_next;
    logic [arbf_pkg::COORD_W-1:0] pend_x_reg, pend_x_next;
    logic [arbf_pkg::COORD_W-1:0] pend_row_reg, pend_row_next;
    logic [arbf_pkg::STAT_W-1:0]  pend_sts_reg, pend_sts_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [23:0]                  m_tdata_reg, m_tdata_next;

    arbf_pkg::srch_t              chain [MAX_SEGMENTS+1];
    logic [MAX_SEGMENTS-1:0]      active_vec;
    arbf_pkg::srch_t              tail;

    logic [arbf_pkg::WIDTH_W-1:0] side;
    logic [arbf_pkg::WIDTH_W-1:0] req_w;
    logic [arbf_pkg::WIDTH_W-1:0] rows_plus;
    logic [arbf_pkg::WIDTH_W-1:0] rem;
    logic                         accept;

    assign side   = (side_cfg_reg > arbf_pkg::GRID_MAX) ? arbf_pkg::GRID_MAX : side_cfg_reg;
    assign req_w  = s_tdata[arbf_pkg::WIDTH_W-1:0];
    assign accept = s_tvalid && s_tready;
    assign tail   = chain[MAX_SEGMENTS];

    assign rows_plus = {1'b0, rows_reg} + 11'd1;
    assign rem       = side - tail.req_width;

    // cell chain
    assign chain[0] = inj_reg;
    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        arbf_cell #(.IDX(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .rec_in  (chain[g]),
            .cmd     (cmd_reg),
            .rec_out (chain[g+1])
        );
        assign active_vec[g] = chain[g+1].active;
    end

    // sequencing, decision and output register
    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        inj_next      = inj_reg;
        inj_next.active = 1'b0;
        cmd_next      = '0;
        cmd_next.op   = arbf_pkg::CMD_NONE;
        pend_x_next   = pend_x_reg;
        pend_row_next = pend_row_reg;
        pend_sts_next = pend_sts_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_x_next   = '0;
                    pend_row_next = '0;
                    pend_sts_next = arbf_pkg::STS_OK;
                    if (s_tuser == arbf_pkg::OP_START) begin
                        cmd_next.op    = arbf_pkg::CMD_SEED;
                        cmd_next.width = side;
                        rows_next      = '0;
                        state_next     = ST_OUT;
                    end else if (req_w == '0 || req_w > side) begin
                        pend_sts_next = arbf_pkg::STS_BADW;
                        state_next    = ST_OUT;
                    end else begin
                        inj_next.active    = 1'b1;
                        inj_next.req_width = req_w;
                        inj_next.best_hit  = 1'b0;
                        inj_next.free_hit  = 1'b0;
                        state_next         = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (tail.active) begin
                    state_next = ST_OUT;
                    if (tail.best_hit) begin
                        cmd_next.op    = arbf_pkg::CMD_SHRINK;
                        cmd_next.slot  = tail.best_idx;
                        cmd_next.width = tail.req_width;
                        pend_x_next    = tail.best_x;
                        pend_row_next  = tail.best_row;
                    end else if (rows_plus >= side) begin
                        pend_sts_next = arbf_pkg::STS_ROWS;
                    end else if (rem != '0 && !tail.free_hit) begin
                        pend_sts_next = arbf_pkg::STS_FULL;
                    end else begin
                        rows_next     = rows_plus[arbf_pkg::COORD_W-1:0];
                        pend_row_next = rows_plus[arbf_pkg::COORD_W-1:0];
                        if (rem != '0) begin
                            cmd_next.op    = arbf_pkg::CMD_WRITE;
                            cmd_next.slot  = tail.free_idx;
                            cmd_next.x     = tail.req_width[arbf_pkg::COORD_W-1:0];
                            cmd_next.row   = rows_plus[arbf_pkg::COORD_W-1:0];
                            cmd_next.width = rem;
                        end
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, pend_sts_reg, pend_row_reg, pend_x_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_x_reg   <= pend_x_next;
        pend_row_reg <= pend_row_next;
        pend_sts_reg <= pend_sts_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rows_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            side_cfg_reg <= 11'd16;
            cmd_reg      <= '0;
            inj_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            m_tvalid_reg <= m_tvalid_next;
            cmd_reg      <= cmd_next;
            inj_reg      <= inj_next;
            if (cfg_valid && cfg_ready) begin
                side_cfg_reg <= cfg_data;
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // at most one search record travels along the chain
    a_one_record: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(active_vec))
        else $error("more than one search record in the cell chain");

    // the record leaves the chain only while the sequencer waits for it
    a_tail_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.active |-> state_reg == ST_SEARCH)
        else $error("search record left the chain outside the search state");

    // segment updates are issued only together with a pending result
    a_cmd_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg.op != arbf_pkg::CMD_NONE |-> state_reg == ST_OUT)
        else $error("segment update without a pending result");

    // rejected items carry no placement
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[21:20] != arbf_pkg::STS_OK) |->
        m_tdata_reg[19:0] == '0)
        else $error("error result with a nonzero placement");

endmodule

// ===== rtl/arbf_cell.sv =====
`timescale 1ns / 1ps

module arbf_cell #(
    parameter int IDX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  arbf_pkg::srch_t rec_in,
    input  arbf_pkg::cmd_t  cmd,
    output arbf_pkg::srch_t rec_out
);

    localparam logic [arbf_pkg::SLOT_W-1:0] SLOT_ID = arbf_pkg::SLOT_W'(IDX);

    logic [arbf_pkg::COORD_W-1:0] x_reg, x_next;
    logic [arbf_pkg::COORD_W-1:0] row_reg, row_next;
    logic [arbf_pkg::WIDTH_W-1:0] width_reg, width_next;
    logic                         valid_reg, valid_next;
    arbf_pkg::srch_t              rec_reg, rec_next;
    logic                         slot_hit;

    assign slot_hit = (cmd.slot == SLOT_ID);

    // fold this segment into the passing search record
    always_comb begin
        rec_next = rec_in;
        if (rec_in.active) begin
            if (!valid_reg) begin
                if (!rec_in.free_hit) begin
                    rec_next.free_hit = 1'b1;
                    rec_next.free_idx = SLOT_ID;
                end
            end else if (width_reg >= rec_in.req_width &&
                         (!rec_in.best_hit || width_reg < rec_in.best_width)) begin
                rec_next.best_hit   = 1'b1;
                rec_next.best_idx   = SLOT_ID;
                rec_next.best_x     = x_reg;
                rec_next.best_row   = row_reg;
                rec_next.best_width = width_reg;
            end
        end
    end

    // segment update from the broadcast command
    always_comb begin
        x_next     = x_reg;
        row_next   = row_reg;
        width_next = width_reg;
        valid_next = valid_reg;
        case (cmd.op)
            arbf_pkg::CMD_SHRINK: begin
                if (slot_hit) begin
                    x_next     = x_reg + cmd.width[arbf_pkg::COORD_W-1:0];
                    width_next = width_reg - cmd.width;
                    valid_next = (width_reg != cmd.width);
                end
            end
            arbf_pkg::CMD_WRITE: begin
                if (slot_hit) begin
                    x_next     = cmd.x;
                    row_next   = cmd.row;
                    width_next = cmd.width;
                    valid_next = 1'b1;
                end
            end
            arbf_pkg::CMD_SEED: begin
                if (IDX == 0) begin
                    x_next     = '0;
                    row_next   = '0;
                    width_next = cmd.width;
                    valid_next = (cmd.width != '0);
                end else begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // segment payload
    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        row_reg   <= row_next;
        width_reg <= width_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rec_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            rec_reg   <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule
